// ----- hw/rtl/rvex_pkg.sv -----
// Shared types and constants for the RV32IM/Zicsr execute unit.
// Depends on nothing; every other file of the block but rvex_if imports it.
package rvex_pkg;

    // Operation codes as delivered by the decoder.
    localparam logic [5:0] OP_LUI     = 6'd0;
    localparam logic [5:0] OP_AUIPC   = 6'd1;
    localparam logic [5:0] OP_JAL     = 6'd2;
    localparam logic [5:0] OP_JALR    = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_BLT     = 6'd6;
    localparam logic [5:0] OP_BGE     = 6'd7;
    localparam logic [5:0] OP_BLTU    = 6'd8;
    localparam logic [5:0] OP_BGEU    = 6'd9;
    localparam logic [5:0] OP_LB      = 6'd10;
    localparam logic [5:0] OP_LH      = 6'd11;
    localparam logic [5:0] OP_LW      = 6'd12;
    localparam logic [5:0] OP_LBU     = 6'd13;
    localparam logic [5:0] OP_LHU     = 6'd14;
    localparam logic [5:0] OP_SB      = 6'd15;
    localparam logic [5:0] OP_SH      = 6'd16;
    localparam logic [5:0] OP_SW      = 6'd17;
    localparam logic [5:0] OP_ADDI    = 6'd18;
    localparam logic [5:0] OP_SLTI    = 6'd19;
    localparam logic [5:0] OP_SLTIU   = 6'd20;
    localparam logic [5:0] OP_XORI    = 6'd21;
    localparam logic [5:0] OP_ORI     = 6'd22;
    localparam logic [5:0] OP_ANDI    = 6'd23;
    localparam logic [5:0] OP_SLLI    = 6'd24;
    localparam logic [5:0] OP_SRLI    = 6'd25;
    localparam logic [5:0] OP_SRAI    = 6'd26;
    localparam logic [5:0] OP_ADD     = 6'd27;
    localparam logic [5:0] OP_SUB     = 6'd28;
    localparam logic [5:0] OP_SLL     = 6'd29;
    localparam logic [5:0] OP_SLT     = 6'd30;
    localparam logic [5:0] OP_SLTU    = 6'd31;
    localparam logic [5:0] OP_XOR     = 6'd32;
    localparam logic [5:0] OP_SRL     = 6'd33;
    localparam logic [5:0] OP_SRA     = 6'd34;
    localparam logic [5:0] OP_OR      = 6'd35;
    localparam logic [5:0] OP_AND     = 6'd36;
    localparam logic [5:0] OP_MUL     = 6'd37;
    localparam logic [5:0] OP_MULH    = 6'd38;
    localparam logic [5:0] OP_MULHSU  = 6'd39;
    localparam logic [5:0] OP_MULHU   = 6'd40;
    localparam logic [5:0] OP_DIV     = 6'd41;
    localparam logic [5:0] OP_DIVU    = 6'd42;
    localparam logic [5:0] OP_REM     = 6'd43;
    localparam logic [5:0] OP_REMU    = 6'd44;
    localparam logic [5:0] OP_CSRRW   = 6'd45;
    localparam logic [5:0] OP_CSRRS   = 6'd46;
    localparam logic [5:0] OP_CSRRC   = 6'd47;
    localparam logic [5:0] OP_CSRRWI  = 6'd48;
    localparam logic [5:0] OP_CSRRSI  = 6'd49;
    localparam logic [5:0] OP_CSRRCI  = 6'd50;
    localparam logic [5:0] OP_FENCE   = 6'd51;
    localparam logic [5:0] OP_FENCEI  = 6'd52;
    localparam logic [5:0] OP_ECALL   = 6'd53;
    localparam logic [5:0] OP_EBREAK  = 6'd54;

    // Result status codes.
    localparam logic [1:0] ST_RETIRE = 2'd0;
    localparam logic [1:0] ST_TRAP   = 2'd1;
    localparam logic [1:0] ST_HALT   = 2'd2;

    // Trap causes.
    localparam logic [1:0] CAUSE_ILLEGAL   = 2'd0;
    localparam logic [1:0] CAUSE_ECALL     = 2'd1;
    localparam logic [1:0] CAUSE_BREAK     = 2'd2;
    localparam logic [1:0] CAUSE_MISALIGN  = 2'd3;

    // Memory request kinds.
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOADU = 2'd1;
    localparam logic [1:0] MEM_LOADS = 2'd2;
    localparam logic [1:0] MEM_STORE = 2'd3;

    // CSR access classes.
    localparam logic [1:0] CSR_RW = 2'd1;
    localparam logic [1:0] CSR_RO = 2'd2;

    // Pipeline depths, counted from the input register.
    localparam int XLEN    = 32;
    localparam int MUL_LAT = 3;
    localparam int DIV_LAT = XLEN + 2;

    // One accepted instruction.
    typedef struct packed {
        logic [5:0]  req_type;
        logic [31:0] pc;
        logic [31:0] rs1_value;
        logic [31:0] rs2_value;
        logic [31:0] immediate;
        logic [2:0]  instr_length;
        logic [4:0]  dest_index;
        logic [4:0]  src1_index;
        logic [31:0] csr_current;
        logic [1:0]  csr_access;
        logic [31:0] raw_word;
    } item_t;

    // One result, plus selects for the multiply and divide units.
    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  trap_cause;
        logic [31:0] trap_value;
        logic [4:0]  rd_write_index;
        logic [31:0] rd_value;
        logic [31:0] next_pc;
        logic [1:0]  mem_op;
        logic [31:0] mem_addr;
        logic [2:0]  mem_size;
        logic [31:0] store_data;
        logic        csr_write;
        logic [31:0] csr_new_value;
        logic        sel_mul;
        logic        sel_div;
    } rec_t;

endpackage

// ----- hw/rtl/rvex_if.sv -----
// Valid/ready channel interfaces for the execute unit's input and result items.
// Depends on nothing.
interface rvex_req_if;
    logic               valid;
    logic               ready;
    logic [5:0]         req_type;
    logic [31:0]        pc;
    logic [31:0]        rs1_value;
    logic [31:0]        rs2_value;
    logic signed [31:0] immediate;
    logic [2:0]         instr_length;
    logic [4:0]         dest_index;
    logic [4:0]         src1_index;
    logic [31:0]        csr_current;
    logic [1:0]         csr_access;
    logic [31:0]        raw_word;

    modport source (output valid, req_type, pc, rs1_value, rs2_value, immediate,
                    instr_length, dest_index, src1_index, csr_current, csr_access,
                    raw_word, input ready);
    modport sink (input valid, req_type, pc, rs1_value, rs2_value, immediate,
                  instr_length, dest_index, src1_index, csr_current, csr_access,
                  raw_word, output ready);
endinterface

interface rvex_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [1:0]  trap_cause;
    logic [31:0] trap_value;
    logic [4:0]  rd_write_index;
    logic [31:0] rd_value;
    logic [31:0] next_pc;
    logic [1:0]  mem_op;
    logic [31:0] mem_addr;
    logic [2:0]  mem_size;
    logic [31:0] store_data;
    logic        csr_write;
    logic [31:0] csr_new_value;

    modport source (output valid, status, trap_cause, trap_value, rd_write_index,
                    rd_value, next_pc, mem_op, mem_addr, mem_size, store_data,
                    csr_write, csr_new_value, input ready);
    modport sink (input valid, status, trap_cause, trap_value, rd_write_index,
                  rd_value, next_pc, mem_op, mem_addr, mem_size, store_data,
                  csr_write, csr_new_value, output ready);
endinterface

// ----- hw/rtl/rvex_alu.sv -----
// Combinational part of execute: ALU, branches, loads/stores, CSR and traps.
// Depends on rvex_pkg.
module rvex_alu
    import rvex_pkg::*;
(
    input  item_t item,
    input  logic  ebreak_traps,
    output rec_t  rec
);

    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm;
    logic [31:0] len32;
    logic [31:0] seq_pc;
    logic [4:0]  sh_imm;
    logic [4:0]  sh_reg;
    logic        lt_s;
    logic        lt_u;
    logic        lt_si;
    logic        lt_ui;
    logic        wr;
    logic        csr_imm;
    logic [31:0] csr_src;
    logic        csr_do_write;
    logic        csr_do_read;
    logic [31:0] csr_nv;
    rec_t        r;

    assign a      = item.rs1_value;
    assign b      = item.rs2_value;
    assign imm    = item.immediate;
    assign len32  = {29'd0, item.instr_length};
    assign seq_pc = item.pc + len32;
    assign sh_imm = imm[4:0];
    assign sh_reg = b[4:0];
    assign lt_s   = $signed(a) < $signed(b);
    assign lt_u   = a < b;
    assign lt_si  = $signed(a) < $signed(imm);
    assign lt_ui  = a < imm;

    // CSR operand and write/read suppression.
    assign csr_imm = (item.req_type == OP_CSRRWI) || (item.req_type == OP_CSRRSI)
                  || (item.req_type == OP_CSRRCI);
    assign csr_src = csr_imm ? imm : a;

    always_comb
    begin
        csr_nv       = csr_src;
        csr_do_write = 1'b1;
        csr_do_read  = (item.dest_index != 5'd0);
        case (item.req_type) inside
            OP_CSRRS, OP_CSRRSI:
            begin
                csr_nv       = item.csr_current | csr_src;
                csr_do_write = csr_imm ? (imm != 32'd0) : (item.src1_index != 5'd0);
                csr_do_read  = 1'b1;
            end
            OP_CSRRC, OP_CSRRCI:
            begin
                csr_nv       = item.csr_current & ~csr_src;
                csr_do_write = csr_imm ? (imm != 32'd0) : (item.src1_index != 5'd0);
                csr_do_read  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Operation decode.
    always_comb
    begin
        r            = '0;
        r.next_pc    = seq_pc;
        wr           = 1'b0;
        unique case (item.req_type) inside
            OP_LUI:    begin wr = 1'b1; r.rd_value = imm; end
            OP_AUIPC:  begin wr = 1'b1; r.rd_value = item.pc + imm; end
            OP_JAL:
            begin
                wr = 1'b1; r.rd_value = seq_pc; r.next_pc = item.pc + imm;
            end
            OP_JALR:
            begin
                wr = 1'b1; r.rd_value = seq_pc; r.next_pc = (a + imm) & ~32'd1;
            end
            OP_BEQ:    if (a == b) r.next_pc = item.pc + imm;
            OP_BNE:    if (a != b) r.next_pc = item.pc + imm;
            OP_BLT:    if (lt_s) r.next_pc = item.pc + imm;
            OP_BGE:    if (!lt_s) r.next_pc = item.pc + imm;
            OP_BLTU:   if (lt_u) r.next_pc = item.pc + imm;
            OP_BGEU:   if (!lt_u) r.next_pc = item.pc + imm;
            OP_LB:     begin r.mem_op = MEM_LOADS; r.mem_size = 3'd1; end
            OP_LH:     begin r.mem_op = MEM_LOADS; r.mem_size = 3'd2; end
            OP_LW:     begin r.mem_op = MEM_LOADU; r.mem_size = 3'd4; end
            OP_LBU:    begin r.mem_op = MEM_LOADU; r.mem_size = 3'd1; end
            OP_LHU:    begin r.mem_op = MEM_LOADU; r.mem_size = 3'd2; end
            OP_SB:     begin r.mem_op = MEM_STORE; r.mem_size = 3'd1; r.store_data = b; end
            OP_SH:     begin r.mem_op = MEM_STORE; r.mem_size = 3'd2; r.store_data = b; end
            OP_SW:     begin r.mem_op = MEM_STORE; r.mem_size = 3'd4; r.store_data = b; end
            OP_ADDI:   begin wr = 1'b1; r.rd_value = a + imm; end
            OP_SLTI:   begin wr = 1'b1; r.rd_value = {31'd0, lt_si}; end
            OP_SLTIU:  begin wr = 1'b1; r.rd_value = {31'd0, lt_ui}; end
            OP_XORI:   begin wr = 1'b1; r.rd_value = a ^ imm; end
            OP_ORI:    begin wr = 1'b1; r.rd_value = a | imm; end
            OP_ANDI:   begin wr = 1'b1; r.rd_value = a & imm; end
            OP_SLLI:   begin wr = 1'b1; r.rd_value = a << sh_imm; end
            OP_SRLI:   begin wr = 1'b1; r.rd_value = a >> sh_imm; end
            OP_SRAI:   begin wr = 1'b1; r.rd_value = $unsigned($signed(a) >>> sh_imm); end
            OP_ADD:    begin wr = 1'b1; r.rd_value = a + b; end
            OP_SUB:    begin wr = 1'b1; r.rd_value = a - b; end
            OP_SLL:    begin wr = 1'b1; r.rd_value = a << sh_reg; end
            OP_SLT:    begin wr = 1'b1; r.rd_value = {31'd0, lt_s}; end
            OP_SLTU:   begin wr = 1'b1; r.rd_value = {31'd0, lt_u}; end
            OP_XOR:    begin wr = 1'b1; r.rd_value = a ^ b; end
            OP_SRL:    begin wr = 1'b1; r.rd_value = a >> sh_reg; end
            OP_SRA:    begin wr = 1'b1; r.rd_value = $unsigned($signed(a) >>> sh_reg); end
            OP_OR:     begin wr = 1'b1; r.rd_value = a | b; end
            OP_AND:    begin wr = 1'b1; r.rd_value = a & b; end
            OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU:
            begin
                wr = 1'b1; r.sel_mul = 1'b1;
            end
            OP_DIV, OP_DIVU, OP_REM, OP_REMU:
            begin
                wr = 1'b1; r.sel_div = 1'b1;
            end
            OP_CSRRW, OP_CSRRS, OP_CSRRC, OP_CSRRWI, OP_CSRRSI, OP_CSRRCI:
            begin
                if ((item.csr_access != CSR_RW && item.csr_access != CSR_RO)
                    || (csr_do_write && item.csr_access == CSR_RO))
                begin
                    r.status     = ST_TRAP;
                    r.trap_cause = CAUSE_ILLEGAL;
                    r.trap_value = item.raw_word;
                end
                else
                begin
                    r.csr_write     = csr_do_write;
                    r.csr_new_value = csr_do_write ? csr_nv : 32'd0;
                    wr              = csr_do_read;
                    r.rd_value      = item.csr_current;
                end
            end
            OP_FENCE, OP_FENCEI:
            begin
            end
            OP_ECALL:
            begin
                r.status = ST_TRAP; r.trap_cause = CAUSE_ECALL;
            end
            OP_EBREAK:
            begin
                if (ebreak_traps)
                begin
                    r.status = ST_TRAP; r.trap_cause = CAUSE_BREAK; r.trap_value = item.pc;
                end
                else
                begin
                    r.status = ST_HALT;
                end
            end
            default:
            begin
                r.status = ST_TRAP; r.trap_cause = CAUSE_ILLEGAL; r.trap_value = item.raw_word;
            end
        endcase

        if (r.mem_op != MEM_NONE)
        begin
            r.mem_addr = a + imm;
        end

        // Odd control-flow target.
        if (r.status == ST_RETIRE && r.next_pc[0])
        begin
            r.status     = ST_TRAP;
            r.trap_cause = CAUSE_MISALIGN;
            r.trap_value = r.next_pc;
        end

        // A trap or halt suppresses every side effect.
        if (r.status != ST_RETIRE)
        begin
            wr              = 1'b0;
            r.mem_op        = MEM_NONE;
            r.mem_addr      = '0;
            r.mem_size      = '0;
            r.store_data    = '0;
            r.csr_write     = 1'b0;
            r.csr_new_value = '0;
        end

        if (wr && item.dest_index != 5'd0)
        begin
            r.rd_write_index = item.dest_index;
        end
        else
        begin
            r.rd_write_index = '0;
            r.rd_value       = '0;
            r.sel_mul        = 1'b0;
            r.sel_div        = 1'b0;
        end
        rec = r;
    end

endmodule

// ----- hw/rtl/rvex_mul.sv -----
// Three-stage multiplier for MUL, MULH, MULHSU and MULHU.
// Depends on rvex_pkg; 17x17 partial products, then two adder stages.
module rvex_mul
    import rvex_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic        a_signed,
    input  logic        b_signed,
    input  logic        want_high,
    output logic [31:0] res
);

    logic signed [16:0] al;
    logic signed [16:0] ah;
    logic signed [16:0] bl;
    logic signed [16:0] bh;

    logic [31:0]        p_ll_reg;
    logic signed [33:0] p_lh_reg;
    logic signed [33:0] p_hl_reg;
    logic signed [33:0] p_hh_reg;
    logic               hi1_reg;

    logic [31:0]        p_ll2_reg;
    logic signed [34:0] mid_reg;
    logic signed [33:0] p_hh2_reg;
    logic               hi2_reg;

    logic signed [63:0] full;

    // Split operands: low halves unsigned, high halves carry the sign.
    assign al = $signed({1'b0, a[15:0]});
    assign bl = $signed({1'b0, b[15:0]});
    assign ah = $signed({a_signed & a[31], a[31:16]});
    assign bh = $signed({b_signed & b[31], b[31:16]});

    // Stage one: partial products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ll_reg <= a[15:0] * b[15:0];
            p_lh_reg <= al * bh;
            p_hl_reg <= ah * bl;
            p_hh_reg <= ah * bh;
            hi1_reg  <= want_high;
        end
    end

    // Stage two: combine the cross terms.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ll2_reg <= p_ll_reg;
            mid_reg   <= 35'(p_lh_reg) + 35'(p_hl_reg);
            p_hh2_reg <= p_hh_reg;
            hi2_reg   <= hi1_reg;
        end
    end

    // Stage three: final sum and half select.
    assign full = (64'(p_hh2_reg) <<< 32) + (64'(mid_reg) <<< 16)
                + $signed({32'd0, p_ll2_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res <= hi2_reg ? full[63:32] : full[31:0];
        end
    end

endmodule

// ----- hw/rtl/rvex_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, one item per cycle while en is high.
// Depends on rvex_pkg; the operands pass an input register, the step registers and res.
module rvex_div
    import rvex_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic        signed_op,
    input  logic        want_rem,
    output logic [31:0] res
);

    typedef struct packed {
        logic neg_q;
        logic neg_r;
        logic want_rem;
    } dflag_t;

    logic        na;
    logic        nb;
    logic [31:0] ma;
    logic [31:0] mb;

    logic [31:0] rem_reg [0:XLEN];
    logic [31:0] num_reg [0:XLEN];
    logic [31:0] quo_reg [0:XLEN];
    logic [31:0] dvs_reg [0:XLEN];
    dflag_t      fl_reg  [0:XLEN];

    logic [31:0] q_fix;
    logic [31:0] r_fix;

    // Operand magnitudes and result signs; a zero divisor keeps q all ones.
    assign na = signed_op & a[31];
    assign nb = signed_op & b[31];
    assign ma = na ? (32'd0 - a) : a;
    assign mb = nb ? (32'd0 - b) : b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]         <= '0;
            num_reg[0]         <= ma;
            quo_reg[0]         <= '0;
            dvs_reg[0]         <= mb;
            fl_reg[0].neg_q    <= (na != nb) && (b != 32'd0);
            fl_reg[0].neg_r    <= na;
            fl_reg[0].want_rem <= want_rem;
        end
    end

    // One shift-subtract step per stage.
    for (genvar j = 0; j < XLEN; j++)
    begin : g_step
        logic [32:0] sh;
        logic [33:0] diff;
        logic        ge;

        assign sh   = {rem_reg[j], num_reg[j][31]};
        assign diff = {1'b0, sh} - {2'b00, dvs_reg[j]};
        assign ge   = !diff[33];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= ge ? diff[31:0] : sh[31:0];
                num_reg[j+1] <= {num_reg[j][30:0], 1'b0};
                quo_reg[j+1] <= {quo_reg[j][30:0], ge};
                dvs_reg[j+1] <= dvs_reg[j];
                fl_reg[j+1]  <= fl_reg[j];
            end
        end
    end

    // Restore signs and pick quotient or remainder.
    assign q_fix = fl_reg[XLEN].neg_q ? (32'd0 - quo_reg[XLEN]) : quo_reg[XLEN];
    assign r_fix = fl_reg[XLEN].neg_r ? (32'd0 - rem_reg[XLEN]) : rem_reg[XLEN];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res <= fl_reg[XLEN].want_rem ? r_fix : q_fix;
        end
    end

endmodule

// ----- hw/rtl/rv32im_execute_unit_top.sv -----
// Channel    | Dir | Payload
// req        | in  | decoded instruction item (rvex_req_if, sink)
// rsp        | out | execute result item (rvex_rsp_if, source)
// cfg        | in  | ebreak_traps write (cfg_we, cfg_wdata)
//
// One item is accepted per cycle while the pipeline advances; each result passes the
// input register, a result line matched to the one-bit-per-stage divider and the output register.
// The whole pipeline advances together when the output register is empty or taken.
// rst_n clears all valid bits and sets ebreak_traps to 1.
// Depends on rvex_pkg, rvex_if, rvex_alu, rvex_mul and rvex_div.
module rv32im_execute_unit_top
    import rvex_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    rvex_req_if.sink   req,
    rvex_rsp_if.source rsp
);

    logic        en;
    logic        ebreak_traps_reg;
    logic        v1_reg;
    item_t       item1_reg;
    item_t       item_in;
    rec_t        rec_new;
    logic        vp_reg  [0:DIV_LAT-1];
    rec_t        rec_reg [0:DIV_LAT-1];
    logic [31:0] mul_res;
    logic [31:0] mul_dly_reg [0:DIV_LAT-MUL_LAT-1];
    logic [31:0] div_res;
    rec_t        fin;
    logic        out_valid_reg;
    rec_t        out_reg;

    // The pipeline moves whenever the output stage can take a new item.
    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ebreak_traps_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            ebreak_traps_reg <= cfg_wdata;
        end
    end

    // Input register.
    assign item_in = '{req_type: req.req_type, pc: req.pc, rs1_value: req.rs1_value,
                       rs2_value: req.rs2_value, immediate: $unsigned(req.immediate),
                       instr_length: req.instr_length, dest_index: req.dest_index,
                       src1_index: req.src1_index, csr_current: req.csr_current,
                       csr_access: req.csr_access, raw_word: req.raw_word};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item1_reg <= item_in;
        end
    end

    // Combinational execute logic.
    rvex_alu u_alu (
        .item         (item1_reg),
        .ebreak_traps (ebreak_traps_reg),
        .rec          (rec_new)
    );

    // Multiply and divide units run beside the result line.
    rvex_mul u_mul (
        .clk       (clk),
        .en        (en),
        .a         (item1_reg.rs1_value),
        .b         (item1_reg.rs2_value),
        .a_signed  (item1_reg.req_type == OP_MULH || item1_reg.req_type == OP_MULHSU),
        .b_signed  (item1_reg.req_type == OP_MULH),
        .want_high (item1_reg.req_type != OP_MUL),
        .res       (mul_res)
    );

    rvex_div u_div (
        .clk       (clk),
        .en        (en),
        .a         (item1_reg.rs1_value),
        .b         (item1_reg.rs2_value),
        .signed_op (item1_reg.req_type == OP_DIV || item1_reg.req_type == OP_REM),
        .want_rem  (item1_reg.req_type == OP_REM || item1_reg.req_type == OP_REMU),
        .res       (div_res)
    );

    // Result line that keeps each record aligned with the divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                vp_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vp_reg[0] <= v1_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                vp_reg[i] <= vp_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rec_reg[0] <= rec_new;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                rec_reg[i] <= rec_reg[i-1];
            end
            mul_dly_reg[0] <= mul_res;
            for (int i = 1; i < DIV_LAT - MUL_LAT; i++)
            begin
                mul_dly_reg[i] <= mul_dly_reg[i-1];
            end
        end
    end

    // Merge the unit results into the record.
    always_comb
    begin
        fin = rec_reg[DIV_LAT-1];
        if (fin.sel_mul)
        begin
            fin.rd_value = mul_dly_reg[DIV_LAT-MUL_LAT-1];
        end
        else if (fin.sel_div)
        begin
            fin.rd_value = div_res;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vp_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= fin;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.trap_cause     = out_reg.trap_cause;
    assign rsp.trap_value     = out_reg.trap_value;
    assign rsp.rd_write_index = out_reg.rd_write_index;
    assign rsp.rd_value       = out_reg.rd_value;
    assign rsp.next_pc        = out_reg.next_pc;
    assign rsp.mem_op         = out_reg.mem_op;
    assign rsp.mem_addr       = out_reg.mem_addr;
    assign rsp.mem_size       = out_reg.mem_size;
    assign rsp.store_data     = out_reg.store_data;
    assign rsp.csr_write      = out_reg.csr_write;
    assign rsp.csr_new_value  = out_reg.csr_new_value;

`ifndef ASSERT_OFF
    // A trap or halt never reports a side effect.
    a_no_effect_on_trap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_RETIRE |->
        rsp.rd_write_index == 5'd0 && rsp.mem_op == MEM_NONE && !rsp.csr_write)
        else $error("side effect reported with a trap or halt");

    // Memory fields are zero without a request.
    a_mem_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.mem_op == MEM_NONE |->
        rsp.mem_size == 3'd0 && rsp.mem_addr == 32'd0)
        else $error("memory fields set without a request");

    // Trap fields are zero unless a trap is raised.
    a_trap_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_TRAP |->
        rsp.trap_cause == 2'd0 && rsp.trap_value == 32'd0)
        else $error("trap fields set without a trap");

    // A stalled output freezes the whole pipeline, input included.
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !req.ready)
        else $error("input accepted while output stalled");
`endif

endmodule

// ----- bench/tb_if.sv -----
`timescale 1ns / 1ps
// Testbench copy note: the channel interfaces live with the RTL (rvex_if.sv).
// This file holds the small type shared by the bench; depends on rvex_pkg.
package tb_exec_pkg;
    import rvex_pkg::*;

    // One expected result of the execute unit.
    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  trap_cause;
        logic [31:0] trap_value;
        logic [4:0]  rd_write_index;
        logic [31:0] rd_value;
        logic [31:0] next_pc;
        logic [1:0]  mem_op;
        logic [31:0] mem_addr;
        logic [2:0]  mem_size;
        logic [31:0] store_data;
        logic        csr_write;
        logic [31:0] csr_new_value;
    } exec_res_t;
endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for rv32im_execute_unit_top: directed and random instructions are
// predicted in the bench and compared with every result; uses rvex_pkg, rvex_if.
module tb_top;
    import rvex_pkg::*;
    import tb_exec_pkg::*;

    localparam int LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    rvex_req_if req();
    rvex_rsp_if rsp();

    rv32im_execute_unit_top uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .req(req), .rsp(rsp)
    );

    bit        ebreak_traps_m;
    exec_res_t pending_results[$];
    int        mismatches = 0;
    int        cycles = 0;
    int        send_idle_pct;
    int        recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed_less(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // Predicts the single result of one instruction.
    function automatic exec_res_t execute_instr(item_t it);
        exec_res_t r;
        logic [31:0] a, b, imm, nv, src, len32;
        logic [63:0] prod;
        logic [31:0] ma, mb, q, rm;
        logic taken, wr, is_imm, do_wr, do_rd;
        int kind;
        a = it.rs1_value;
        b = it.rs2_value;
        imm = it.immediate;
        len32 = {29'd0, it.instr_length};
        r = '0;
        wr = 1'b0;
        r.next_pc = it.pc + len32;
        if (it.req_type >= OP_BEQ && it.req_type <= OP_BGEU)
        begin
            case (it.req_type)
                OP_BEQ:  taken = (a == b);
                OP_BNE:  taken = (a != b);
                OP_BLT:  taken = signed_less(a, b);
                OP_BGE:  taken = !signed_less(a, b);
                OP_BLTU: taken = (a < b);
                default: taken = (a >= b);
            endcase
            if (taken)
                r.next_pc = it.pc + imm;
        end
        else if (it.req_type >= OP_LB && it.req_type <= OP_SW)
        begin
            r.mem_addr = a + imm;
            case (it.req_type)
                OP_LB:   begin r.mem_op = MEM_LOADS; r.mem_size = 3'd1; end
                OP_LH:   begin r.mem_op = MEM_LOADS; r.mem_size = 3'd2; end
                OP_LW:   begin r.mem_op = MEM_LOADU; r.mem_size = 3'd4; end
                OP_LBU:  begin r.mem_op = MEM_LOADU; r.mem_size = 3'd1; end
                OP_LHU:  begin r.mem_op = MEM_LOADU; r.mem_size = 3'd2; end
                OP_SB:   begin r.mem_op = MEM_STORE; r.mem_size = 3'd1; end
                OP_SH:   begin r.mem_op = MEM_STORE; r.mem_size = 3'd2; end
                default: begin r.mem_op = MEM_STORE; r.mem_size = 3'd4; end
            endcase
            if (r.mem_op == MEM_STORE)
                r.store_data = b;
        end
        else if (it.req_type >= OP_CSRRW && it.req_type <= OP_CSRRCI)
        begin
            is_imm = it.req_type >= OP_CSRRWI;
            src = is_imm ? imm : a;
            kind = is_imm ? int'(it.req_type - OP_CSRRWI) : int'(it.req_type - OP_CSRRW);
            if (kind == 0)
            begin
                nv = src;
                do_wr = 1'b1;
                do_rd = (it.dest_index != 5'd0);
            end
            else
            begin
                nv = (kind == 1) ? (it.csr_current | src) : (it.csr_current & ~src);
                do_wr = is_imm ? (imm != 32'd0) : (it.src1_index != 5'd0);
                do_rd = 1'b1;
            end
            if ((it.csr_access != CSR_RW && it.csr_access != CSR_RO)
                || (do_wr && it.csr_access == CSR_RO))
            begin
                r.status = ST_TRAP;
                r.trap_cause = CAUSE_ILLEGAL;
                r.trap_value = it.raw_word;
            end
            else
            begin
                if (do_wr)
                begin
                    r.csr_write = 1'b1;
                    r.csr_new_value = nv;
                end
                if (do_rd)
                begin
                    wr = 1'b1;
                    r.rd_value = it.csr_current;
                end
            end
        end
        else
        begin
            wr = 1'b1;
            case (it.req_type)
                OP_LUI:   r.rd_value = imm;
                OP_AUIPC: r.rd_value = it.pc + imm;
                OP_JAL:
                begin
                    r.rd_value = it.pc + len32;
                    r.next_pc = it.pc + imm;
                end
                OP_JALR:
                begin
                    r.rd_value = it.pc + len32;
                    r.next_pc = (a + imm) & ~32'd1;
                end
                OP_ADDI:  r.rd_value = a + imm;
                OP_SLTI:  r.rd_value = {31'd0, signed_less(a, imm)};
                OP_SLTIU: r.rd_value = {31'd0, (a < imm)};
                OP_XORI:  r.rd_value = a ^ imm;
                OP_ORI:   r.rd_value = a | imm;
                OP_ANDI:  r.rd_value = a & imm;
                OP_SLLI:  r.rd_value = a << imm[4:0];
                OP_SRLI:  r.rd_value = a >> imm[4:0];
                OP_SRAI:  r.rd_value = $unsigned($signed(a) >>> imm[4:0]);
                OP_ADD:   r.rd_value = a + b;
                OP_SUB:   r.rd_value = a - b;
                OP_SLL:   r.rd_value = a << b[4:0];
                OP_SLT:   r.rd_value = {31'd0, signed_less(a, b)};
                OP_SLTU:  r.rd_value = {31'd0, (a < b)};
                OP_XOR:   r.rd_value = a ^ b;
                OP_SRL:   r.rd_value = a >> b[4:0];
                OP_SRA:   r.rd_value = $unsigned($signed(a) >>> b[4:0]);
                OP_OR:    r.rd_value = a | b;
                OP_AND:   r.rd_value = a & b;
                OP_MUL:   r.rd_value = a * b;
                OP_MULH:
                begin
                    prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                    r.rd_value = prod[63:32];
                end
                OP_MULHSU:
                begin
                    prod = {{32{a[31]}}, a} * {32'd0, b};
                    r.rd_value = prod[63:32];
                end
                OP_MULHU:
                begin
                    prod = {32'd0, a} * {32'd0, b};
                    r.rd_value = prod[63:32];
                end
                OP_DIV, OP_REM:
                begin
                    ma = a[31] ? -a : a;
                    mb = b[31] ? -b : b;
                    if (b == 32'd0)
                    begin
                        q = '1;
                        rm = a;
                    end
                    else
                    begin
                        q = ma / mb;
                        rm = ma % mb;
                        if (a[31] != b[31])
                            q = -q;
                        if (a[31])
                            rm = -rm;
                    end
                    r.rd_value = (it.req_type == OP_DIV) ? q : rm;
                end
                OP_DIVU:  r.rd_value = (b == 32'd0) ? '1 : a / b;
                OP_REMU:  r.rd_value = (b == 32'd0) ? a : a % b;
                OP_FENCE, OP_FENCEI: wr = 1'b0;
                OP_ECALL:
                begin
                    wr = 1'b0;
                    r.status = ST_TRAP;
                    r.trap_cause = CAUSE_ECALL;
                end
                OP_EBREAK:
                begin
                    wr = 1'b0;
                    if (ebreak_traps_m)
                    begin
                        r.status = ST_TRAP;
                        r.trap_cause = CAUSE_BREAK;
                        r.trap_value = it.pc;
                    end
                    else
                        r.status = ST_HALT;
                end
                default:
                begin
                    wr = 1'b0;
                    r.status = ST_TRAP;
                    r.trap_cause = CAUSE_ILLEGAL;
                    r.trap_value = it.raw_word;
                end
            endcase
        end
        // A retiring instruction with an odd target traps as misaligned.
        if (r.status == ST_RETIRE && r.next_pc[0])
        begin
            r.status = ST_TRAP;
            r.trap_cause = CAUSE_MISALIGN;
            r.trap_value = r.next_pc;
        end
        // Traps and halts cancel every side effect.
        if (r.status != ST_RETIRE)
        begin
            wr = 1'b0;
            r.mem_op = MEM_NONE;
            r.mem_addr = '0;
            r.mem_size = '0;
            r.store_data = '0;
            r.csr_write = 1'b0;
            r.csr_new_value = '0;
        end
        if (wr && it.dest_index != 5'd0)
            r.rd_write_index = it.dest_index;
        else
            r.rd_value = '0;
        return r;
    endfunction

    // Sends one item, with random idle cycles before it.
    task automatic send_instr(item_t it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.req_type <= it.req_type;
        req.pc <= it.pc;
        req.rs1_value <= it.rs1_value;
        req.rs2_value <= it.rs2_value;
        req.immediate <= it.immediate;
        req.instr_length <= it.instr_length;
        req.dest_index <= it.dest_index;
        req.src1_index <= it.src1_index;
        req.csr_current <= it.csr_current;
        req.csr_access <= it.csr_access;
        req.raw_word <= it.raw_word;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_results.push_back(execute_instr(it));
    endtask

    task automatic go_idle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DIV_LAT + 10) @(posedge clk);
    endtask

    task automatic write_ebreak_traps(bit v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        ebreak_traps_m = v;
    endtask

    function automatic logic [31:0] edge_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t random_instr();
        item_t it;
        it.req_type = ($urandom_range(19) == 0) ? 6'($urandom_range(55, 63))
                                                : 6'($urandom_range(54));
        it.pc = $urandom;
        // Mostly even pcs and even offsets so most instructions get past the
        // misaligned-target check.
        if ($urandom_range(9) != 0)
            it.pc[0] = 1'b0;
        it.rs1_value = edge_word();
        it.rs2_value = ($urandom_range(7) == 0) ? 32'd0 : edge_word();
        it.immediate = ($urandom_range(5) == 0) ? 32'd0 : edge_word();
        if ($urandom_range(9) != 0)
            it.immediate[0] = 1'b0;
        it.instr_length = ($urandom_range(19) == 0) ? 3'($urandom_range(7))
                                                    : ($urandom_range(1) ? 3'd4 : 3'd2);
        it.dest_index = ($urandom_range(5) == 0) ? 5'd0 : 5'($urandom);
        it.src1_index = ($urandom_range(4) == 0) ? 5'd0 : 5'($urandom);
        it.csr_current = $urandom;
        it.csr_access = 2'($urandom_range(3));
        it.raw_word = $urandom;
        return it;
    endfunction

    function automatic item_t base_instr(logic [5:0] op);
        item_t it;
        it = '0;
        it.req_type = op;
        it.pc = 32'h0000_1000;
        it.instr_length = 3'd4;
        it.dest_index = 5'd5;
        it.src1_index = 5'd3;
        it.csr_access = CSR_RW;
        it.raw_word = 32'hdead_beef;
        return it;
    endfunction

    // Field extremes, every operation and the named corner cases.
    task automatic test_directed();
        item_t it;
        for (int op = 0; op < 56; op++)
        begin
            it = base_instr(6'(op));
            it.rs1_value = 32'h8000_0000;
            it.rs2_value = 32'hffff_ffff;
            it.immediate = 32'hffff_fff0;
            it.csr_current = 32'h0f0f_0f0f;
            send_instr(it);
        end
        it = base_instr(OP_DIV);
        it.rs1_value = 32'h1234_5678;
        send_instr(it);
        it.req_type = OP_REMU;
        send_instr(it);
        it = base_instr(OP_JALR);
        it.rs1_value = 32'hffff_ffff;
        it.immediate = 32'h7fff_ffff;
        send_instr(it);
        it = base_instr(OP_JAL);
        it.immediate = 32'd3;
        send_instr(it);
        it = base_instr(OP_CSRRS);
        it.src1_index = 5'd0;
        it.csr_access = CSR_RO;
        send_instr(it);
        it = base_instr(OP_CSRRWI);
        it.dest_index = 5'd0;
        it.csr_access = 2'd3;
        send_instr(it);
        it = base_instr(OP_ADD);
        it.pc = 32'hffff_fffe;
        it.instr_length = 3'd7;
        it.dest_index = 5'd31;
        send_instr(it);
    endtask

    task automatic test_ebreak_modes();
        item_t it;
        go_idle();
        write_ebreak_traps(1'b0);
        it = base_instr(OP_EBREAK);
        send_instr(it);
        it.pc = 32'hffff_fffc;
        send_instr(it);
        go_idle();
        write_ebreak_traps(1'b1);
        send_instr(it);
    endtask

    task automatic test_random(int n, int idle, int stall);
        go_idle();
        send_idle_pct = idle;
        recv_stall_pct = stall;
        write_ebreak_traps(1'($urandom_range(1)));
        repeat (n) send_instr(random_instr());
    endtask

    // Receiver: random stalls and comparison with the oldest prediction.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                exec_res_t e;
                exec_res_t g;
                g.status = rsp.status;
                g.trap_cause = rsp.trap_cause;
                g.trap_value = rsp.trap_value;
                g.rd_write_index = rsp.rd_write_index;
                g.rd_value = rsp.rd_value;
                g.next_pc = rsp.next_pc;
                g.mem_op = rsp.mem_op;
                g.mem_addr = rsp.mem_addr;
                g.mem_size = rsp.mem_size;
                g.store_data = rsp.store_data;
                g.csr_write = rsp.csr_write;
                g.csr_new_value = rsp.csr_new_value;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: %p", g);
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (e !== g)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", e, g);
                    end
                end
            end
            rsp.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        req.valid = 1'b0;
        req.req_type = '0;
        req.pc = '0;
        req.rs1_value = '0;
        req.rs2_value = '0;
        req.immediate = '0;
        req.instr_length = '0;
        req.dest_index = '0;
        req.src1_index = '0;
        req.csr_current = '0;
        req.csr_access = '0;
        req.raw_word = '0;
        ebreak_traps_m = 1'b1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_ebreak_modes();
        test_random(300, 0, 0);
        test_random(250, 78, 0);
        test_random(250, 0, 78);
        test_random(250, 23, 23);
        go_idle();
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/rvex_pkg.sv
hw/rtl/rvex_if.sv
hw/rtl/rvex_alu.sv
hw/rtl/rvex_mul.sv
hw/rtl/rvex_div.sv
hw/rtl/rv32im_execute_unit_top.sv
bench/tb_if.sv
bench/tb_top.sv
